@@ sv/square_tone_sweep_generator_macros.svh @@
// ----------------------------------------------------------------------------
// Square tone sweep generator assertion macros
// Shared concurrent assertion forms for the generator's checker.
// ----------------------------------------------------------------------------
`ifndef SQUARE_TONE_SWEEP_GENERATOR_MACROS_SVH
`define SQUARE_TONE_SWEEP_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled in reset
`define STSG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define STSG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/stsg_pkg.sv @@
// ----------------------------------------------------------------------------
// Square tone sweep generator package
// Widths, register indexes, control types and the base amplitude table.
// ----------------------------------------------------------------------------
package stsg_pkg;

    // field widths
    localparam int IDX_W       = 24;
    localparam int FREQ_W      = 16;
    localparam int VOL_W       = 17;
    localparam int LEVEL_W     = 2;
    localparam int SAMPLE_W    = 13;
    localparam int PHASE_W     = 32;
    localparam int FREQ16_W    = 32;
    localparam int VOL32_W     = 33;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // progress is Q1.16 with values up to 1.0, so 17 quotient bits
    localparam int PROG_BITS = 17;

    // base amplitude multiplier, one bit per step
    localparam int BASE_W    = 12;
    localparam int AMP_W     = 12;
    localparam int AMP_STEPS = BASE_W;

    localparam logic [VOL_W-1:0] VOL_ONE = 17'd65536;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLED         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_LEVEL    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_FREQUENCY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_FREQUENCY   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_SAMPLES   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_START_VOLUME    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_END_VOLUME      = 3'd6;

    // load / step strobes for a serial unit
    typedef struct packed {
        logic load;
        logic run;
    } serial_ctrl_t;

    // base amplitude by volume level
    function automatic logic [BASE_W-1:0] base_amp(input logic [LEVEL_W-1:0] level);
        logic [BASE_W-1:0] amp;
        case (level)
            2'd1:    amp = 12'd600;
            2'd2:    amp = 12'd1500;
            2'd3:    amp = 12'd3000;
            default: amp = 12'd0;
        endcase
        return amp;
    endfunction

endpackage

@@ sv/square_tone_sweep_generator.sv @@
// ----------------------------------------------------------------------------
// Square tone sweep generator
// One square-wave sample per input transfer, with frequency and volume swept
// linearly from start to end values across the tone.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//  in      | in_valid/in_ready    | restart
//  out     | out_valid/out_ready  | sample, sample_valid, last
//
// An active tick runs, after its input transfer, the PROG_BITS progress
// divider steps, a load cycle, the INC_STEPS increment divider steps, a finish
// cycle and the output load before out_valid rises; an idle tick goes straight
// to the output load. In both cases in_ready returns in the same cycle as
// out_valid rises. One tick is in work at a time; a stalled
// output holds the block in its done state, and the output register lets the
// next input transfer happen while a result waits. Reset clears the phase,
// index and registers to their reset values; cfg_ready stays high.
// ----------------------------------------------------------------------------
module square_tone_sweep_generator #(
    parameter int SAMPLE_RATE_HZ = 44100
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [stsg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [stsg_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  restart,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [stsg_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  sample_valid,
    output logic                                  last
);

    localparam int INC_STEPS = 48 - $clog2(SAMPLE_RATE_HZ + 1);
    localparam int MAX_STEPS = (INC_STEPS > stsg_pkg::PROG_BITS) ? INC_STEPS
                                                                 : stsg_pkg::PROG_BITS;
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int IW    = stsg_pkg::IDX_W;
    localparam int SW    = stsg_pkg::SAMPLE_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_TONE  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                           state_reg, state_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic                                 enabled_reg, enabled_next;
    logic [stsg_pkg::LEVEL_W-1:0]         level_reg, level_next;
    logic signed [stsg_pkg::FREQ_W-1:0]   start_freq_reg, start_freq_next;
    logic signed [stsg_pkg::FREQ_W-1:0]   end_freq_reg, end_freq_next;
    logic [IW-1:0]                        total_reg, total_next;
    logic [stsg_pkg::VOL_W-1:0]           start_vol_reg, start_vol_next;
    logic [stsg_pkg::VOL_W-1:0]           end_vol_reg, end_vol_next;
    logic [stsg_pkg::PHASE_W-1:0]         phase_reg, phase_next;
    logic [IW-1:0]                        idx_reg, idx_next;
    logic signed [SW-1:0]                 res_sample_reg, res_sample_next;
    logic                                 res_valid_reg, res_valid_next;
    logic                                 res_last_reg, res_last_next;
    logic                                 out_valid_reg, out_valid_next;
    logic signed [SW-1:0]                 sample_reg;
    logic                                 sample_valid_reg;
    logic                                 last_reg;
    logic                                 out_load;

    logic [IW-1:0]                        idx_eff;
    logic                                 hit;
    logic signed [SW-1:0]                 amp_ext;
    stsg_pkg::serial_ctrl_t               sweep_ctrl;
    stsg_pkg::serial_ctrl_t               tone_ctrl;
    logic signed [stsg_pkg::FREQ16_W-1:0] freq16;
    logic [stsg_pkg::VOL32_W-1:0]         vol32;
    logic [stsg_pkg::PHASE_W-1:0]         inc;
    logic [stsg_pkg::AMP_W-1:0]           amp;
    logic                                 freq_pos;

    // progress divider and interpolation
    stsg_sweep u_sweep (
        .clk             (clk),
        .ctrl            (sweep_ctrl),
        .sample_idx      (idx_eff),
        .total_samples   (total_reg),
        .start_frequency (start_freq_reg),
        .end_frequency   (end_freq_reg),
        .start_volume    (start_vol_reg),
        .end_volume      (end_vol_reg),
        .freq16          (freq16),
        .vol32           (vol32)
    );

    // phase increment and amplitude
    stsg_tone #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
        .INC_STEPS      (INC_STEPS)
    ) u_tone (
        .clk          (clk),
        .ctrl         (tone_ctrl),
        .freq16       (freq16),
        .vol32        (vol32),
        .volume_level (level_reg),
        .inc          (inc),
        .amp          (amp),
        .freq_pos     (freq_pos)
    );

    // restart only counts while the input is open; later the stored index rules
    assign idx_eff = (in_ready && restart) ? '0 : idx_reg;
    assign hit     = freq_pos && (amp != '0);
    assign amp_ext = $signed({1'b0, amp});

    // sequencer, tick update and config writes
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        enabled_next    = enabled_reg;
        level_next      = level_reg;
        start_freq_next = start_freq_reg;
        end_freq_next   = end_freq_reg;
        total_next      = total_reg;
        start_vol_next  = start_vol_reg;
        end_vol_next    = end_vol_reg;
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        res_sample_next = res_sample_reg;
        res_valid_next  = res_valid_reg;
        res_last_next   = res_last_reg;
        out_load        = 1'b0;
        sweep_ctrl      = '0;
        tone_ctrl       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = idx_eff;
                    if (enabled_reg && (idx_eff < total_reg))
                    begin
                        sweep_ctrl.load = 1'b1;
                        cnt_next        = CNT_W'(stsg_pkg::PROG_BITS);
                        state_next      = S_SWEEP;
                    end
                    else
                    begin
                        // idle tick: empty result; the phase is held and the index only moves on restart
                        res_sample_next = '0;
                        res_valid_next  = 1'b0;
                        res_last_next   = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_SWEEP:
            begin
                if (cnt_reg != '0)
                begin
                    sweep_ctrl.run = 1'b1;
                    cnt_next       = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    tone_ctrl.load = 1'b1;
                    cnt_next       = CNT_W'(INC_STEPS);
                    state_next     = S_TONE;
                end
            end
            S_TONE:
            begin
                if (cnt_reg != '0)
                begin
                    tone_ctrl.run = 1'b1;
                    cnt_next      = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    // low half of the cycle gives the negative level
                    if (hit)
                    begin
                        res_sample_next = phase_reg[stsg_pkg::PHASE_W-1] ? amp_ext
                                                                         : -amp_ext;
                        phase_next      = phase_reg + inc;
                    end
                    else
                    begin
                        res_sample_next = '0;
                    end
                    res_valid_next = 1'b1;
                    res_last_next  = (idx_reg == (total_reg - IW'(1)));
                    idx_next       = idx_reg + IW'(1);
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes; enable change restarts the phase
        if (cfg_valid)
        begin
            case (cfg_index)
                stsg_pkg::REG_ENABLED:
                begin
                    if (cfg_data[0] != enabled_reg)
                    begin
                        phase_next = '0;
                    end
                    enabled_next = cfg_data[0];
                end
                stsg_pkg::REG_VOLUME_LEVEL:
                    level_next = cfg_data[stsg_pkg::LEVEL_W-1:0];
                stsg_pkg::REG_START_FREQUENCY:
                    start_freq_next = $signed(cfg_data[stsg_pkg::FREQ_W-1:0]);
                stsg_pkg::REG_END_FREQUENCY:
                    end_freq_next = $signed(cfg_data[stsg_pkg::FREQ_W-1:0]);
                stsg_pkg::REG_TOTAL_SAMPLES:
                    total_next = cfg_data[IW-1:0];
                stsg_pkg::REG_START_VOLUME:
                    start_vol_next = cfg_data[stsg_pkg::VOL_W-1:0];
                stsg_pkg::REG_END_VOLUME:
                    end_vol_next = cfg_data[stsg_pkg::VOL_W-1:0];
                default:
                begin
                end
            endcase
        end

        // output register valid
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            enabled_reg    <= 1'b0;
            level_reg      <= '0;
            start_freq_reg <= '0;
            end_freq_reg   <= '0;
            total_reg      <= '0;
            start_vol_reg  <= stsg_pkg::VOL_ONE;
            end_vol_reg    <= stsg_pkg::VOL_ONE;
            phase_reg      <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            enabled_reg    <= enabled_next;
            level_reg      <= level_next;
            start_freq_reg <= start_freq_next;
            end_freq_reg   <= end_freq_next;
            total_reg      <= total_next;
            start_vol_reg  <= start_vol_next;
            end_vol_reg    <= end_vol_next;
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result and output payload
    always_ff @(posedge clk)
    begin
        res_sample_reg <= res_sample_next;
        res_valid_reg  <= res_valid_next;
        res_last_reg   <= res_last_next;
        if (out_load)
        begin
            sample_reg       <= res_sample_reg;
            sample_valid_reg <= res_valid_reg;
            last_reg         <= res_last_reg;
        end
    end

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;
    assign sample_valid = sample_valid_reg;
    assign last         = last_reg;

endmodule

@@ sv/stsg_sweep.sv @@
// ----------------------------------------------------------------------------
// Sweep interpolator
// Restoring divider for progress = index/(total-1), one quotient bit per
// cycle, MSB first, feeding two shift-add accumulators that form the
// interpolated frequency (Q16.16) and volume (Q1.32).
// ----------------------------------------------------------------------------
module stsg_sweep (
    input  logic                                  clk,
    input  stsg_pkg::serial_ctrl_t                ctrl,
    input  logic [stsg_pkg::IDX_W-1:0]            sample_idx,
    input  logic [stsg_pkg::IDX_W-1:0]            total_samples,
    input  logic signed [stsg_pkg::FREQ_W-1:0]    start_frequency,
    input  logic signed [stsg_pkg::FREQ_W-1:0]    end_frequency,
    input  logic [stsg_pkg::VOL_W-1:0]            start_volume,
    input  logic [stsg_pkg::VOL_W-1:0]            end_volume,
    output logic signed [stsg_pkg::FREQ16_W-1:0]  freq16,
    output logic [stsg_pkg::VOL32_W-1:0]          vol32
);

    localparam int IW  = stsg_pkg::IDX_W;
    localparam int FDW = stsg_pkg::FREQ_W + 1;
    localparam int VDW = stsg_pkg::VOL_W + 1;
    localparam int FAW = FDW + stsg_pkg::PROG_BITS;
    localparam int VAW = VDW + stsg_pkg::PROG_BITS;

    logic [IW-1:0]              den;
    logic                       single;
    logic [IW:0]                rem_reg;
    logic [IW:0]                rem_next;
    logic [IW:0]                shifted;
    logic                       first_reg;
    logic                       first_next;
    logic                       ge;
    logic                       q;
    logic [stsg_pkg::VOL_W-1:0] sv_c;
    logic [stsg_pkg::VOL_W-1:0] ev_c;
    logic signed [FDW-1:0]      fdiff;
    logic signed [VDW-1:0]      vdiff;
    logic signed [FAW-1:0]      facc_reg;
    logic signed [FAW-1:0]      facc_next;
    logic signed [VAW-1:0]      vacc_reg;
    logic signed [VAW-1:0]      vacc_next;

    // divisor and the single-sample case (progress is 1.0)
    assign den    = total_samples - IW'(1);
    assign single = (total_samples == IW'(1));

    // volume clamp to 1.0
    assign sv_c = (start_volume > stsg_pkg::VOL_ONE) ? stsg_pkg::VOL_ONE : start_volume;
    assign ev_c = (end_volume > stsg_pkg::VOL_ONE) ? stsg_pkg::VOL_ONE : end_volume;

    assign fdiff = $signed({end_frequency[stsg_pkg::FREQ_W-1], end_frequency})
                 - $signed({start_frequency[stsg_pkg::FREQ_W-1], start_frequency});
    assign vdiff = $signed({1'b0, ev_c}) - $signed({1'b0, sv_c});

    // one divider step; the only nonzero dividend bit left is index bit 0
    always_comb
    begin
        shifted  = {rem_reg[IW-1:0], first_reg & sample_idx[0]};
        ge       = (shifted >= {1'b0, den});
        q        = single ? first_reg : ge;
        rem_next = ge ? (shifted - {1'b0, den}) : shifted;
        first_next = 1'b0;
        facc_next  = (facc_reg <<< 1) + (q ? FAW'(fdiff) : '0);
        vacc_next  = (vacc_reg <<< 1) + (q ? VAW'(vdiff) : '0);
    end

    // serial state; upper dividend bits reduce to index >> 1
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg   <= {2'b00, sample_idx[IW-1:1]};
            first_reg <= 1'b1;
            facc_reg  <= '0;
            vacc_reg  <= '0;
        end
        else if (ctrl.run)
        begin
            rem_reg   <= rem_next;
            first_reg <= first_next;
            facc_reg  <= facc_next;
            vacc_reg  <= vacc_next;
        end
    end

    // start value plus slope times progress
    assign freq16 = $signed({start_frequency, 16'h0000})
                  + $signed(facc_reg[stsg_pkg::FREQ16_W-1:0]);
    assign vol32  = {sv_c, 16'h0000} + vacc_reg[stsg_pkg::VOL32_W-1:0];

endmodule

@@ sv/stsg_tone.sv @@
// ----------------------------------------------------------------------------
// Tone step unit
// Restoring divider by the sample rate for the phase increment, one bit per
// cycle, and an LSB-first shift-add multiplier for base amplitude * volume.
// ----------------------------------------------------------------------------
module stsg_tone #(
    parameter int SAMPLE_RATE_HZ = 44100,
    parameter int INC_STEPS      = 32
) (
    input  logic                                 clk,
    input  stsg_pkg::serial_ctrl_t               ctrl,
    input  logic signed [stsg_pkg::FREQ16_W-1:0] freq16,
    input  logic [stsg_pkg::VOL32_W-1:0]         vol32,
    input  logic [stsg_pkg::LEVEL_W-1:0]         volume_level,
    output logic [stsg_pkg::PHASE_W-1:0]         inc,
    output logic [stsg_pkg::AMP_W-1:0]           amp,
    output logic                                 freq_pos
);

    localparam int REM_W   = $clog2(SAMPLE_RATE_HZ) + 1;
    localparam int DVD_W   = stsg_pkg::FREQ16_W + 16;
    localparam int VW      = stsg_pkg::VOL32_W;
    localparam int AMP_LSB = 32 - stsg_pkg::BASE_W;
    localparam int ACW     = $clog2(stsg_pkg::AMP_STEPS + 1);
    localparam logic [REM_W-1:0] RATE = REM_W'(SAMPLE_RATE_HZ);

    logic [DVD_W-1:0]                dividend;
    logic [INC_STEPS-1:0]            num_reg;
    logic [REM_W-1:0]                rem_reg;
    logic [REM_W-1:0]                shifted;
    logic                            ge;
    logic [stsg_pkg::PHASE_W-1:0]    quo_reg;
    logic                            pos_reg;
    logic [VW-1:0]                   vol_reg;
    logic [stsg_pkg::BASE_W-1:0]     base_reg;
    logic [VW-1:0]                   hacc_reg;
    logic [VW:0]                     hsum;
    logic [ACW-1:0]                  amp_cnt_reg;

    assign dividend = {freq16, 16'h0000};

    // increment divider step
    assign shifted = {rem_reg[REM_W-2:0], num_reg[INC_STEPS-1]};
    assign ge      = (shifted >= RATE);

    // amplitude multiplier step: add, then drop the settled low bit
    assign hsum = {1'b0, hacc_reg} + (base_reg[0] ? {1'b0, vol_reg} : '0);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            num_reg     <= dividend[INC_STEPS-1:0];
            rem_reg     <= REM_W'(dividend >> INC_STEPS);
            quo_reg     <= '0;
            pos_reg     <= !freq16[stsg_pkg::FREQ16_W-1] && (freq16 != '0);
            vol_reg     <= vol32;
            base_reg    <= stsg_pkg::base_amp(volume_level);
            hacc_reg    <= '0;
            amp_cnt_reg <= ACW'(stsg_pkg::AMP_STEPS);
        end
        else if (ctrl.run)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? (shifted - RATE) : shifted;
            quo_reg <= {quo_reg[stsg_pkg::PHASE_W-2:0], ge};
            if (amp_cnt_reg != '0)
            begin
                hacc_reg    <= hsum[VW:1];
                base_reg    <= base_reg >> 1;
                amp_cnt_reg <= amp_cnt_reg - ACW'(1);
            end
        end
    end

    assign inc      = quo_reg;
    assign amp      = hacc_reg[AMP_LSB +: stsg_pkg::AMP_W];
    assign freq_pos = pos_reg;

endmodule

@@ sv/stsg_checker.sv @@
// ----------------------------------------------------------------------------
// Square tone sweep generator port checker
// Port-level properties of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "square_tone_sweep_generator_macros.svh"

module stsg_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [stsg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input logic [stsg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 restart,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [stsg_pkg::SAMPLE_W-1:0] sample,
    input logic                                 sample_valid,
    input logic                                 last
);

    // stalled output transfer holds its payload
    `STSG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample) && $stable(sample_valid) && $stable(last), "output payload changed while stalled")

    // one tick in work at a time
    `STSG_ASSERT_NEXT(a_in_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input accepted while a tick is in work")

    // empty ticks carry a zero sample and no end mark
    `STSG_ASSERT_NOW(a_idle_zero, clk, rst_n, out_valid && !sample_valid, (sample == '0) && !last, "idle tick with nonzero sample or last")

    // sample stays within the largest base amplitude
    `STSG_ASSERT_NOW(a_sample_range, clk, rst_n, out_valid, ($signed(sample) >= -3000) && ($signed(sample) <= 3000), "sample out of range")

    // last only on a produced sample
    `STSG_ASSERT_NOW(a_last_valid, clk, rst_n, out_valid && last, sample_valid, "last on an idle tick")

endmodule

bind square_tone_sweep_generator stsg_checker u_stsg_checker (.*);
